### design/dwpd_pkg.sv
// ----------------------------------------------------------------------------
// dwpd_pkg
// Shared types and constants for the dual wheel PD speed controller.
// ----------------------------------------------------------------------------
package dwpd_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_SCALE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_SLOPE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CMD_OFFSET  = 3'd5;

	localparam logic [31:0] RST_PROP_GAIN   = 32'd131072;
	localparam logic [31:0] RST_DERIV_GAIN  = 32'd6554;
	localparam logic [31:0] RST_INV_RADIUS  = 32'd2184533;
	localparam logic [31:0] RST_COUNT_SCALE = 32'd328;
	localparam logic [31:0] RST_CMD_SLOPE   = 32'd2107110;
	localparam logic [31:0] RST_CMD_OFFSET  = 32'd1310720;

	localparam logic [6:0] CMD_LIMIT = 7'd127;

	// multiplier operand pair select
	localparam int MSEL_W = 3;
	localparam logic [MSEL_W-1:0] MSEL_NONE = 3'd0;
	localparam logic [MSEL_W-1:0] MSEL_RATE = 3'd1;
	localparam logic [MSEL_W-1:0] MSEL_MEAS = 3'd2;
	localparam logic [MSEL_W-1:0] MSEL_PROP = 3'd3;
	localparam logic [MSEL_W-1:0] MSEL_DER  = 3'd4;
	localparam logic [MSEL_W-1:0] MSEL_CMD  = 3'd5;

	typedef struct packed {
		logic [31:0] prop_gain;
		logic [31:0] deriv_gain;
		logic [31:0] inv_radius;
		logic [31:0] count_scale;
		logic [31:0] cmd_slope;
		logic [31:0] cmd_offset;
	} dwpd_cfg_t;

	typedef struct packed {
		logic              load;
		logic              mul_en;
		logic [MSEL_W-1:0] msel;
		logic              wr_delta;
		logic              wr_rate;
		logic              wr_meas;
		logic              wr_err;
		logic              wr_de;
		logic              wr_p;
		logic              wr_d;
		logic              wr_ctl;
		logic              wr_r;
		logic              commit;
	} dwpd_cmd_t;

endpackage

### design/dwpd_wheel.sv
// ----------------------------------------------------------------------------
// dwpd_wheel
// Datapath for one wheel: shared sign-magnitude multiplier with floor and
// saturation post-stage, error and PD sums, motor command mapping.
// ----------------------------------------------------------------------------
module dwpd_wheel import dwpd_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dwpd_cmd_t          cmd,
	input  dwpd_cfg_t          cfg,
	input  logic signed [31:0] target_speed,
	input  logic signed [31:0] position,
	output logic signed [7:0]  drive_cmd,
	output logic signed [31:0] control,
	output logic signed [31:0] measured_rate
);

	localparam logic [65:0] RND_MASK = (66'd1 << FRAC_BITS) - 66'd1;
	localparam logic [65:0] POS_LIM  = 66'h0_7FFF_FFFF;
	localparam logic [65:0] NEG_LIM  = 66'h0_8000_0000;

	function automatic logic [31:0] sat32(input logic [32:0] v);
		if (v[32] != v[31])
			sat32 = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			sat32 = v[31:0];
	endfunction

	logic [31:0] tgt_q, pos_q, last_pos_q, last_err_q;
	logic [32:0] delta_q, de_q;
	logic [31:0] rate_q, meas_q, e_q, p_q, d_q, c_q, r_q;
	logic [64:0] prod_q;
	logic        neg_q, sh_q;
	logic [7:0]  cmd_out_q;
	logic [31:0] ctl_out_q, meas_out_q;

	logic [32:0] op_a, op_mag;
	logic [31:0] op_b;
	logic [65:0] p_adj, p_shr;
	logic [31:0] post;
	logic [33:0] v_sum, v_neg, v_mag, v_shr;
	logic [6:0]  cmd_mag;
	logic [7:0]  cmd_val;

	always_comb begin
		case (cmd.msel)
			MSEL_RATE: begin
				op_a = {tgt_q[31], tgt_q};
				op_b = cfg.inv_radius;
			end
			MSEL_MEAS: begin
				op_a = delta_q;
				op_b = cfg.count_scale;
			end
			MSEL_PROP: begin
				op_a = {e_q[31], e_q};
				op_b = cfg.prop_gain;
			end
			MSEL_DER: begin
				op_a = de_q;
				op_b = cfg.deriv_gain;
			end
			MSEL_CMD: begin
				op_a = {c_q[31], c_q};
				op_b = cfg.cmd_slope;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		op_mag = op_a[32] ? (~op_a + 33'd1) : op_a;
	end

	always_comb begin
		p_adj = {1'b0, prod_q};
		if (neg_q && sh_q)
			p_adj = {1'b0, prod_q} + RND_MASK;
		p_shr = sh_q ? (p_adj >> FRAC_BITS) : p_adj;
		if (!neg_q)
			post = (p_shr > POS_LIM) ? 32'h7FFF_FFFF : p_shr[31:0];
		else
			post = (p_shr > NEG_LIM) ? 32'h8000_0000 : (~p_shr[31:0] + 32'd1);
	end

	always_comb begin
		v_sum   = {{2{r_q[31]}}, r_q} + {{2{cfg.cmd_offset[31]}}, cfg.cmd_offset};
		v_neg   = ~v_sum + 34'd1;
		v_mag   = v_neg[33] ? (~v_neg + 34'd1) : v_neg;
		v_shr   = v_mag >> FRAC_BITS;
		cmd_mag = (v_shr > {27'd0, CMD_LIMIT}) ? CMD_LIMIT : v_shr[6:0];
		if (c_q == '0)
			cmd_val = '0;
		else if (v_neg[33])
			cmd_val = ~{1'b0, cmd_mag} + 8'd1;
		else
			cmd_val = {1'b0, cmd_mag};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			last_err_q <= '0;
		end else if (cmd.commit) begin
			last_pos_q <= pos_q;
			last_err_q <= e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tgt_q <= target_speed;
			pos_q <= position;
		end
		if (cmd.mul_en) begin
			prod_q <= {32'd0, op_mag} * {33'd0, op_b};
			neg_q  <= op_a[32];
			sh_q   <= (cmd.msel != MSEL_MEAS);
		end
		if (cmd.wr_delta)
			delta_q <= {pos_q[31], pos_q} - {last_pos_q[31], last_pos_q};
		if (cmd.wr_rate)
			rate_q <= post;
		if (cmd.wr_meas)
			meas_q <= post;
		if (cmd.wr_err)
			e_q <= sat32({rate_q[31], rate_q} - {meas_q[31], meas_q});
		if (cmd.wr_de)
			de_q <= {e_q[31], e_q} - {last_err_q[31], last_err_q};
		if (cmd.wr_p)
			p_q <= post;
		if (cmd.wr_d)
			d_q <= post;
		if (cmd.wr_ctl)
			c_q <= sat32({p_q[31], p_q} + {d_q[31], d_q});
		if (cmd.wr_r)
			r_q <= post;
		if (cmd.commit) begin
			cmd_out_q  <= cmd_val;
			ctl_out_q  <= c_q;
			meas_out_q <= meas_q;
		end
	end

	assign drive_cmd     = cmd_out_q;
	assign control       = ctl_out_q;
	assign measured_rate = meas_out_q;

endmodule

### design/dwpd_ctrl.sv
// ----------------------------------------------------------------------------
// dwpd_ctrl
// Sequencer: steps both wheel datapaths through the multiply and sum
// schedule and owns the request handshakes.
// ----------------------------------------------------------------------------
module dwpd_ctrl import dwpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output dwpd_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RATE  = 4'd1;
	localparam logic [3:0] ST_MEAS  = 4'd2;
	localparam logic [3:0] ST_PMEAS = 4'd3;
	localparam logic [3:0] ST_ERR   = 4'd4;
	localparam logic [3:0] ST_PROP  = 4'd5;
	localparam logic [3:0] ST_DER   = 4'd6;
	localparam logic [3:0] ST_PDER  = 4'd7;
	localparam logic [3:0] ST_CTL   = 4'd8;
	localparam logic [3:0] ST_SLOPE = 4'd9;
	localparam logic [3:0] ST_PCMD  = 4'd10;
	localparam logic [3:0] ST_CMD   = 4'd11;

	logic [3:0] state_q, state_nx;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		cmd.msel = MSEL_NONE;
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid)
					state_nx = ST_RATE;
			end
			ST_RATE: begin
				cmd.mul_en   = 1'b1;
				cmd.msel     = MSEL_RATE;
				cmd.wr_delta = 1'b1;
				state_nx     = ST_MEAS;
			end
			ST_MEAS: begin
				cmd.wr_rate = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.msel    = MSEL_MEAS;
				state_nx    = ST_PMEAS;
			end
			ST_PMEAS: begin
				cmd.wr_meas = 1'b1;
				state_nx    = ST_ERR;
			end
			ST_ERR: begin
				cmd.wr_err = 1'b1;
				state_nx   = ST_PROP;
			end
			ST_PROP: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MSEL_PROP;
				cmd.wr_de  = 1'b1;
				state_nx   = ST_DER;
			end
			ST_DER: begin
				cmd.wr_p   = 1'b1;
				cmd.mul_en = 1'b1;
				cmd.msel   = MSEL_DER;
				state_nx   = ST_PDER;
			end
			ST_PDER: begin
				cmd.wr_d = 1'b1;
				state_nx = ST_CTL;
			end
			ST_CTL: begin
				cmd.wr_ctl = 1'b1;
				state_nx   = ST_SLOPE;
			end
			ST_SLOPE: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MSEL_CMD;
				state_nx   = ST_PCMD;
			end
			ST_PCMD: begin
				cmd.wr_r = 1'b1;
				state_nx = ST_CMD;
			end
			ST_CMD: begin
				cmd.commit = !out_valid_q || out_ready;
				if (!out_valid_q || out_ready)
					state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RATE))
		else $error("accepted request did not start the schedule");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMD && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished result not presented");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_CMD))
		else $error("result valid raised outside the commit step");

endmodule

### design/dual_wheel_pd_speed_controller_core.sv
// ----------------------------------------------------------------------------
// dual_wheel_pd_speed_controller_core
// Two-wheel PD angular speed controller with motor command mapping.
//
//   channel | signals                               | transfer
//   --------+---------------------------------------+------------------------
//   in      | in_valid/in_ready, targets, positions | one request at a time
//   out     | out_valid/out_ready, cmds, ctl, meas  | one result per request
//   cfg     | cfg_valid/cfg_ready, index, data      | one register write
//
// A request steps from acceptance to result valid through the multiply/sum
// schedule, five products per wheel on one multiplier each; the idle state
// that follows takes the next request.
// Both wheels run in lockstep in their own datapaths.
// The next request is taken once the previous result sits in the output
// register; a stalled output holds only the final step.
// Reset clears the controller, the previous position and error, and loads
// the default gains. cfg_ready is always high.
// ----------------------------------------------------------------------------
module dual_wheel_pd_speed_controller_core import dwpd_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   left_target_speed,
	input  logic signed [31:0]   right_target_speed,
	input  logic signed [31:0]   left_position,
	input  logic signed [31:0]   right_position,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [7:0]    left_motor_cmd,
	output logic signed [7:0]    right_motor_cmd,
	output logic signed [31:0]   left_control,
	output logic signed [31:0]   right_control,
	output logic signed [31:0]   left_measured_rate,
	output logic signed [31:0]   right_measured_rate,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	dwpd_cfg_t cfg_q;
	dwpd_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= RST_PROP_GAIN;
			cfg_q.deriv_gain  <= RST_DERIV_GAIN;
			cfg_q.inv_radius  <= RST_INV_RADIUS;
			cfg_q.count_scale <= RST_COUNT_SCALE;
			cfg_q.cmd_slope   <= RST_CMD_SLOPE;
			cfg_q.cmd_offset  <= RST_CMD_OFFSET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data;
				CFG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data;
				CFG_INV_RADIUS:  cfg_q.inv_radius  <= cfg_data;
				CFG_COUNT_SCALE: cfg_q.count_scale <= cfg_data;
				CFG_CMD_SLOPE:   cfg_q.cmd_slope   <= cfg_data;
				CFG_CMD_OFFSET:  cfg_q.cmd_offset  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	dwpd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	dwpd_wheel #(.FRAC_BITS(FRAC_BITS)) u_left (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.target_speed  (left_target_speed),
		.position      (left_position),
		.drive_cmd     (left_motor_cmd),
		.control       (left_control),
		.measured_rate (left_measured_rate)
	);

	dwpd_wheel #(.FRAC_BITS(FRAC_BITS)) u_right (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.target_speed  (right_target_speed),
		.position      (right_position),
		.drive_cmd     (right_motor_cmd),
		.control       (right_control),
		.measured_rate (right_measured_rate)
	);

endmodule
